@@ rtl/ethernet_ipv4_l4_header_parser_unit_macros.svh @@
// Assertion helpers for the bound checker module eipp_checker.
`ifndef ETHERNET_IPV4_L4_HEADER_PARSER_UNIT_MACROS_SVH
`define ETHERNET_IPV4_L4_HEADER_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define EIPP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("eipp assertion failed");

// Next-cycle implication, held off while reset is asserted.
`define EIPP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("eipp assertion failed");

`endif

@@ rtl/eipp_pkg.sv @@
package eipp_pkg;

  typedef enum logic [3:0] {
    KIND_SHORT     = 4'd0,
    KIND_ARP       = 4'd1,
    KIND_IPV6      = 4'd2,
    KIND_OTHER_ETH = 4'd3,
    KIND_BAD_IHL   = 4'd4,
    KIND_TCP       = 4'd5,
    KIND_UDP       = 4'd6,
    KIND_ICMP      = 4'd7,
    KIND_OTHER_IP  = 4'd8
  } kind_e;

  localparam logic [15:0] ETH_HDR_BYTES = 16'd14;
  localparam logic [15:0] POS_IHL       = 16'd14;
  localparam logic [15:0] POS_TTL       = 16'd22;
  localparam logic [15:0] POS_PROTO     = 16'd23;
  localparam logic [15:0] POS_SIP       = 16'd26;
  localparam logic [15:0] POS_DIP       = 16'd30;
  localparam logic [15:0] POS_IP_END    = 16'd34;
  localparam logic [15:0] L4_CAPTURE    = 16'd14;
  localparam logic [3:0]  MIN_IHL       = 4'd5;

  localparam logic [15:0] TYPE_IPV4 = 16'h0800;
  localparam logic [15:0] TYPE_ARP  = 16'h0806;
  localparam logic [15:0] TYPE_IPV6 = 16'h86DD;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

endpackage

@@ rtl/ethernet_ipv4_l4_header_parser_unit.sv @@
// Ethernet/IPv4/TCP-UDP header parser. Frame bytes enter one per cycle on the
// input channel, the final byte flagged by last_i; a new byte may be accepted
// every clock while the input is not stalled. Each byte updates a
// 16-bit saturating offset counter and, at most, one field register, where
// the byte lands in its own fixed lane, first byte most significant. The
// byte carrying last_i is classified in the same cycle; its single result
// item is written to the output register at the edge that accepts that byte
// and is offered from the next cycle on, while the field registers clear for
// the next frame. Input is stalled only while that output register holds an
// item the downstream side is stalling. Bytes beyond MAX_FRAME_BYTES are
// counted no further and ignored; header bytes never received read as zero,
// and fields that do not apply to the reported kind are forced to zero.
module ethernet_ipv4_l4_header_parser_unit import eipp_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 65535
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  kind_o,
  output logic [15:0] frame_type_o,
  output logic [47:0] dst_mac_addr_o,
  output logic [47:0] source_mac_o,
  output logic [31:0] source_ip_o,
  output logic [31:0] dest_ip_o,
  output logic [7:0]  time_to_live_o,
  output logic [7:0]  ip_protocol_o,
  output logic [15:0] source_port_o,
  output logic [15:0] dst_port_o,
  output logic [5:0]  tcp_flag_bits_o,
  output logic [15:0] transport_length_o
);

  localparam logic [15:0] MaxBytes = 16'(MAX_FRAME_BYTES);

  // Per-frame state
  logic [15:0] offset_q, offset_d;
  logic [15:0] type_q, type_d;
  logic [47:0] dmac_q, dmac_d;
  logic [47:0] smac_q, smac_d;
  logic [3:0]  ihl_q, ihl_d;
  logic [31:0] sip_q, sip_d;
  logic [31:0] dip_q, dip_d;
  logic [7:0]  ttl_q, ttl_d;
  logic [7:0]  proto_q, proto_d;
  logic [15:0] sport_q, sport_d;
  logic [15:0] dport_q, dport_d;
  logic [15:0] misc_q, misc_d;

  // Result register
  logic        out_valid_q;
  kind_e       kind_q, kind_d;
  logic [15:0] frame_type_q;
  logic [47:0] dst_mac_addr_q, source_mac_q;
  logic [31:0] source_ip_q, source_ip_d, dest_ip_q, dest_ip_d;
  logic [7:0]  ttl_out_q, ttl_out_d, proto_out_q, proto_out_d;
  logic [15:0] sport_out_q, sport_out_d, dport_out_q, dport_out_d;
  logic [5:0]  flags_q, flags_d;
  logic [15:0] tlen_q, tlen_d;

  logic        in_accept, out_accept, take;
  logic [15:0] pos, l4_base;
  logic [3:0]  l4_rel;
  logic        in_l4;
  logic        ip_ok, l4_ok;

  // Hold input while a finished item is waiting downstream.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_accept = out_valid_q && !out_stall_i;

  assign pos  = offset_q;
  assign take = (offset_q < MaxBytes);

  // Transport header starts at 14 + 4*IHL; capture its first 14 bytes.
  assign l4_base = ETH_HDR_BYTES + {10'd0, ihl_q, 2'b00};
  assign l4_rel  = 4'(pos - l4_base);
  assign in_l4   = (ihl_q >= MIN_IHL) && (pos >= l4_base) &&
                   (pos < l4_base + L4_CAPTURE);

  // Field capture: each byte goes to its own lane, first byte on top, so
  // lanes of bytes never received stay zero.
  always_comb begin
    offset_d = offset_q;
    type_d   = type_q;
    dmac_d   = dmac_q;
    smac_d   = smac_q;
    ihl_d    = ihl_q;
    sip_d    = sip_q;
    dip_d    = dip_q;
    ttl_d    = ttl_q;
    proto_d  = proto_q;
    sport_d  = sport_q;
    dport_d  = dport_q;
    misc_d   = misc_q;
    if (take) begin
      offset_d = offset_q + 16'd1;
      if (pos < 16'd6) begin
        for (int i = 0; i < 6; i++) begin
          if (pos == 16'(i)) begin
            dmac_d[8*(5-i) +: 8] = data_byte_i;
          end
        end
      end else if (pos < 16'd12) begin
        for (int i = 0; i < 6; i++) begin
          if (pos == 16'(6 + i)) begin
            smac_d[8*(5-i) +: 8] = data_byte_i;
          end
        end
      end else if (pos < ETH_HDR_BYTES) begin
        if (pos[0]) begin
          type_d[7:0] = data_byte_i;
        end else begin
          type_d[15:8] = data_byte_i;
        end
      end else if (pos == POS_IHL) begin
        ihl_d = data_byte_i[3:0];
      end else if (pos == POS_TTL) begin
        ttl_d = data_byte_i;
      end else if (pos == POS_PROTO) begin
        proto_d = data_byte_i;
      end else if (pos >= POS_SIP && pos < POS_DIP) begin
        for (int i = 0; i < 4; i++) begin
          if (pos == POS_SIP + 16'(i)) begin
            sip_d[8*(3-i) +: 8] = data_byte_i;
          end
        end
      end else if (pos >= POS_DIP && pos < POS_IP_END) begin
        for (int i = 0; i < 4; i++) begin
          if (pos == POS_DIP + 16'(i)) begin
            dip_d[8*(3-i) +: 8] = data_byte_i;
          end
        end
      end
      // Odd transport offsets carry the low byte of each 16-bit field.
      if (in_l4) begin
        if (l4_rel < 4'd2) begin
          if (l4_rel[0]) begin
            sport_d[7:0] = data_byte_i;
          end else begin
            sport_d[15:8] = data_byte_i;
          end
        end else if (l4_rel < 4'd4) begin
          if (l4_rel[0]) begin
            dport_d[7:0] = data_byte_i;
          end else begin
            dport_d[15:8] = data_byte_i;
          end
        end else if ((proto_q == PROTO_UDP && l4_rel < 4'd6) ||
                     (proto_q == PROTO_TCP && l4_rel >= 4'd12)) begin
          if (l4_rel[0]) begin
            misc_d[7:0] = data_byte_i;
          end else begin
            misc_d[15:8] = data_byte_i;
          end
        end
      end
    end
  end

  // Classify on the values that include the current byte.
  always_comb begin
    ip_ok = 1'b0;
    if (offset_d < ETH_HDR_BYTES) begin
      kind_d = KIND_SHORT;
    end else if (type_d != TYPE_IPV4) begin
      if (type_d == TYPE_ARP) begin
        kind_d = KIND_ARP;
      end else if (type_d == TYPE_IPV6) begin
        kind_d = KIND_IPV6;
      end else begin
        kind_d = KIND_OTHER_ETH;
      end
    end else if (ihl_d < MIN_IHL) begin
      kind_d = KIND_BAD_IHL;
    end else begin
      ip_ok = 1'b1;
      if (proto_d == PROTO_TCP) begin
        kind_d = KIND_TCP;
      end else if (proto_d == PROTO_UDP) begin
        kind_d = KIND_UDP;
      end else if (proto_d == PROTO_ICMP) begin
        kind_d = KIND_ICMP;
      end else begin
        kind_d = KIND_OTHER_IP;
      end
    end
  end

  // Drop fields that mean nothing for the reported kind.
  always_comb begin
    l4_ok       = (kind_d == KIND_TCP) || (kind_d == KIND_UDP);
    source_ip_d = ip_ok ? sip_d : 32'd0;
    dest_ip_d   = ip_ok ? dip_d : 32'd0;
    ttl_out_d   = ip_ok ? ttl_d : 8'd0;
    proto_out_d = ip_ok ? proto_d : 8'd0;
    sport_out_d = l4_ok ? sport_d : 16'd0;
    dport_out_d = l4_ok ? dport_d : 16'd0;
    flags_d     = (kind_d == KIND_TCP) ? misc_d[5:0] : 6'd0;
    case (kind_d)
      KIND_TCP: tlen_d = {10'd0, misc_d[15:12], 2'b00};
      KIND_UDP: tlen_d = misc_d;
      default:  tlen_d = 16'd0;
    endcase
  end

  // Advance frame state; clear it once the last byte has been taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      type_q   <= '0;
      dmac_q   <= '0;
      smac_q   <= '0;
      ihl_q    <= '0;
      sip_q    <= '0;
      dip_q    <= '0;
      ttl_q    <= '0;
      proto_q  <= '0;
      sport_q  <= '0;
      dport_q  <= '0;
      misc_q   <= '0;
    end else if (in_accept) begin
      if (last_i) begin
        offset_q <= '0;
        type_q   <= '0;
        dmac_q   <= '0;
        smac_q   <= '0;
        ihl_q    <= '0;
        sip_q    <= '0;
        dip_q    <= '0;
        ttl_q    <= '0;
        proto_q  <= '0;
        sport_q  <= '0;
        dport_q  <= '0;
        misc_q   <= '0;
      end else begin
        offset_q <= offset_d;
        type_q   <= type_d;
        dmac_q   <= dmac_d;
        smac_q   <= smac_d;
        ihl_q    <= ihl_d;
        sip_q    <= sip_d;
        dip_q    <= dip_d;
        ttl_q    <= ttl_d;
        proto_q  <= proto_d;
        sport_q  <= sport_d;
        dport_q  <= dport_d;
        misc_q   <= misc_d;
      end
    end
  end

  // Output valid: set by a last byte, cleared once the item is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept && last_i) begin
      out_valid_q <= 1'b1;
    end else if (out_accept) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_accept && last_i) begin
      kind_q         <= kind_d;
      frame_type_q   <= type_d;
      dst_mac_addr_q <= dmac_d;
      source_mac_q   <= smac_d;
      source_ip_q    <= source_ip_d;
      dest_ip_q      <= dest_ip_d;
      ttl_out_q      <= ttl_out_d;
      proto_out_q    <= proto_out_d;
      sport_out_q    <= sport_out_d;
      dport_out_q    <= dport_out_d;
      flags_q        <= flags_d;
      tlen_q         <= tlen_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign kind_o             = kind_q;
  assign frame_type_o       = frame_type_q;
  assign dst_mac_addr_o     = dst_mac_addr_q;
  assign source_mac_o       = source_mac_q;
  assign source_ip_o        = source_ip_q;
  assign dest_ip_o          = dest_ip_q;
  assign time_to_live_o     = ttl_out_q;
  assign ip_protocol_o      = proto_out_q;
  assign source_port_o      = sport_out_q;
  assign dst_port_o         = dport_out_q;
  assign tcp_flag_bits_o    = flags_q;
  assign transport_length_o = tlen_q;

endmodule

@@ rtl/eipp_checker.sv @@
`include "ethernet_ipv4_l4_header_parser_unit_macros.svh"

module eipp_checker import eipp_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        last_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [3:0]  kind_o,
  input logic [15:0] frame_type_o,
  input logic [47:0] dst_mac_addr_o,
  input logic [47:0] source_mac_o,
  input logic [31:0] source_ip_o,
  input logic [31:0] dest_ip_o,
  input logic [7:0]  time_to_live_o,
  input logic [7:0]  ip_protocol_o,
  input logic [15:0] source_port_o,
  input logic [15:0] dst_port_o,
  input logic [5:0]  tcp_flag_bits_o,
  input logic [15:0] transport_length_o
);

  logic         out_held, last_taken, not_tcp, not_l4, l4_zero;
  logic [249:0] out_payload;

  assign out_held    = out_valid_o && out_stall_i;
  assign last_taken  = in_valid_i && !in_stall_o && last_i;
  assign not_tcp     = out_valid_o && (kind_o != KIND_TCP);
  assign not_l4      = not_tcp && (kind_o != KIND_UDP);
  assign l4_zero     = (source_port_o == 16'd0) && (dst_port_o == 16'd0) &&
                       (transport_length_o == 16'd0);
  assign out_payload = {kind_o, frame_type_o, dst_mac_addr_o, source_mac_o,
                        source_ip_o, dest_ip_o, time_to_live_o, ip_protocol_o,
                        source_port_o, dst_port_o, tcp_flag_bits_o,
                        transport_length_o};

  // A stalled result stays put.
  `EIPP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o && $stable(out_payload))

  // A full, stalled output register must back-pressure the input.
  `EIPP_ASSERT_NOW(a_in_backpressure, clk_i, rst_ni, out_held, in_stall_o)

  // Every accepted last byte yields a result in the next cycle.
  `EIPP_ASSERT_NEXT(a_last_result, clk_i, rst_ni, last_taken, out_valid_o)

  // Flags only for TCP.
  `EIPP_ASSERT_NOW(a_flags_tcp, clk_i, rst_ni, not_tcp, tcp_flag_bits_o == 6'd0)

  // Transport fields only for TCP or UDP.
  `EIPP_ASSERT_NOW(a_l4_zero, clk_i, rst_ni, not_l4, l4_zero)

endmodule

bind ethernet_ipv4_l4_header_parser_unit eipp_checker u_eipp_checker (.*);

@@ tb/sv/ethernet_ipv4_l4_header_parser_unit_checker.sv @@
module ethernet_ipv4_l4_header_parser_unit_checker import eipp_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 65535
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [3:0]  kind_i,
  input  logic [15:0] frame_type_i,
  input  logic [47:0] dst_mac_addr_i,
  input  logic [47:0] source_mac_i,
  input  logic [31:0] source_ip_i,
  input  logic [31:0] dest_ip_i,
  input  logic [7:0]  time_to_live_i,
  input  logic [7:0]  ip_protocol_i,
  input  logic [15:0] source_port_i,
  input  logic [15:0] dst_port_i,
  input  logic [5:0]  tcp_flag_bits_i,
  input  logic [15:0] transport_length_i,
  output int          pending_o,
  output int          fail_count_o
);

  typedef struct packed {
    kind_e       kind;
    logic [15:0] frame_type;
    logic [47:0] dst_mac_addr;
    logic [47:0] source_mac;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [7:0]  time_to_live;
    logic [7:0]  ip_protocol;
    logic [15:0] source_port;
    logic [15:0] dst_port;
    logic [5:0]  tcp_flag_bits;
    logic [15:0] transport_length;
  } frame_summary_t;

  // Shadow of the parser's per-frame field registers.
  logic [15:0] rx_count;
  logic [15:0] eth_type;
  logic [47:0] dst_mac;
  logic [47:0] src_mac;
  logic [3:0]  ip_ihl;
  logic [31:0] src_ip;
  logic [31:0] dst_ip;
  logic [7:0]  ip_ttl;
  logic [7:0]  ip_proto;
  logic [15:0] l4_src_port;
  logic [15:0] l4_dst_port;
  logic [15:0] l4_word;

  frame_summary_t summary_q[$];

  task automatic clear_fields();
    rx_count = '0; eth_type = '0; dst_mac = '0; src_mac = '0; ip_ihl = '0;
    src_ip = '0; dst_ip = '0; ip_ttl = '0; ip_proto = '0;
    l4_src_port = '0; l4_dst_port = '0; l4_word = '0;
  endtask

  task automatic absorb_byte(input logic [7:0] b);
    int p;
    int base;
    int r;
    p = rx_count;
    if (p < 6) dst_mac[8*(5-p) +: 8] = b;
    else if (p < 12) src_mac[8*(11-p) +: 8] = b;
    else if (p < 14) eth_type[8*(13-p) +: 8] = b;
    else if (p == POS_IHL) ip_ihl = b[3:0];
    else if (p == POS_TTL) ip_ttl = b;
    else if (p == POS_PROTO) ip_proto = b;
    else if (p >= POS_SIP && p < POS_DIP) src_ip[8*(29-p) +: 8] = b;
    else if (p >= POS_DIP && p < POS_IP_END) dst_ip[8*(33-p) +: 8] = b;

    // Transport bytes only once a sane IHL has been seen.
    if (ip_ihl >= MIN_IHL) begin
      base = ETH_HDR_BYTES + 4 * ip_ihl;
      if (p >= base && p < base + L4_CAPTURE) begin
        r = p - base;
        if (r < 2) l4_src_port[8*(1-r) +: 8] = b;
        else if (r < 4) l4_dst_port[8*(3-r) +: 8] = b;
        else if (ip_proto == PROTO_UDP && r < 6) l4_word[8*(5-r) +: 8] = b;
        else if (ip_proto == PROTO_TCP && r >= 12) l4_word[8*(13-r) +: 8] = b;
      end
    end
  endtask

  function automatic frame_summary_t summarise_frame();
    frame_summary_t s;
    kind_e k;
    if (rx_count < ETH_HDR_BYTES) k = KIND_SHORT;
    else if (eth_type == TYPE_ARP) k = KIND_ARP;
    else if (eth_type == TYPE_IPV6) k = KIND_IPV6;
    else if (eth_type != TYPE_IPV4) k = KIND_OTHER_ETH;
    else if (ip_ihl < MIN_IHL) k = KIND_BAD_IHL;
    else if (ip_proto == PROTO_TCP) k = KIND_TCP;
    else if (ip_proto == PROTO_UDP) k = KIND_UDP;
    else if (ip_proto == PROTO_ICMP) k = KIND_ICMP;
    else k = KIND_OTHER_IP;

    s = '0;
    s.kind = k;
    s.frame_type = eth_type;
    s.dst_mac_addr = dst_mac;
    s.source_mac = src_mac;
    if (k >= KIND_TCP) begin
      s.source_ip = src_ip;
      s.dest_ip = dst_ip;
      s.time_to_live = ip_ttl;
      s.ip_protocol = ip_proto;
    end
    if (k == KIND_TCP || k == KIND_UDP) begin
      s.source_port = l4_src_port;
      s.dst_port = l4_dst_port;
    end
    if (k == KIND_TCP) begin
      s.tcp_flag_bits = l4_word[5:0];
      s.transport_length = {10'd0, l4_word[15:12], 2'b00};
    end else if (k == KIND_UDP) begin
      s.transport_length = l4_word;
    end
    return s;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    frame_summary_t want;
    if (!rst_ni) begin
      clear_fields();
      summary_q.delete();
      pending_o = 0;
      fail_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (summary_q.size() == 0) begin
          $error("result item with no frame outstanding");
          fail_count_o++;
        end else begin
          want = summary_q.pop_front();
          check_field("kind", 64'(want.kind), 64'(kind_i));
          check_field("frame_type", 64'(want.frame_type), 64'(frame_type_i));
          check_field("dst_mac_addr", 64'(want.dst_mac_addr), 64'(dst_mac_addr_i));
          check_field("source_mac", 64'(want.source_mac), 64'(source_mac_i));
          check_field("source_ip", 64'(want.source_ip), 64'(source_ip_i));
          check_field("dest_ip", 64'(want.dest_ip), 64'(dest_ip_i));
          check_field("time_to_live", 64'(want.time_to_live), 64'(time_to_live_i));
          check_field("ip_protocol", 64'(want.ip_protocol), 64'(ip_protocol_i));
          check_field("source_port", 64'(want.source_port), 64'(source_port_i));
          check_field("dst_port", 64'(want.dst_port), 64'(dst_port_i));
          check_field("tcp_flag_bits", 64'(want.tcp_flag_bits), 64'(tcp_flag_bits_i));
          check_field("transport_length", 64'(want.transport_length),
                      64'(transport_length_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (rx_count < MAX_FRAME_BYTES) begin
          absorb_byte(data_byte_i);
          rx_count = rx_count + 16'd1;
        end
        if (last_i) begin
          summary_q.push_back(summarise_frame());
          clear_fields();
        end
      end
      pending_o = summary_q.size();
    end
  end

endmodule

@@ tb/sv/ethernet_ipv4_l4_header_parser_unit_tb.sv @@
module ethernet_ipv4_l4_header_parser_unit_tb;
  import eipp_pkg::*;

  // Ways of filling the bytes of a frame that the header fields do not set.
  typedef enum {PAD_RANDOM, PAD_ZERO, PAD_ONES} pad_e;

  localparam int TOTAL_BYTES  = 1350;
  localparam int IDLE_PERCENT = 37;
  localparam int HOLD_CYCLES  = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        last_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [3:0]  kind_o;
  logic [15:0] frame_type_o;
  logic [47:0] dst_mac_addr_o;
  logic [47:0] source_mac_o;
  logic [31:0] source_ip_o;
  logic [31:0] dest_ip_o;
  logic [7:0]  time_to_live_o;
  logic [7:0]  ip_protocol_o;
  logic [15:0] source_port_o;
  logic [15:0] dst_port_o;
  logic [5:0]  tcp_flag_bits_o;
  logic [15:0] transport_length_o;

  int pending;
  int fail_count;

  // Shared between the byte sender and the result receiver.
  logic calm     = 1'b0;  // no idling on either side while high
  logic hold_req = 1'b0;  // ask the receiver for its one long hold-off

  logic [7:0] frame_q[$];
  int         bytes_sent;

  always #5 clk_i = ~clk_i;

  ethernet_ipv4_l4_header_parser_unit dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .data_byte_i, .last_i,
    .out_valid_o, .out_stall_i,
    .kind_o, .frame_type_o, .dst_mac_addr_o, .source_mac_o, .source_ip_o, .dest_ip_o,
    .time_to_live_o, .ip_protocol_o, .source_port_o, .dst_port_o,
    .tcp_flag_bits_o, .transport_length_o
  );

  ethernet_ipv4_l4_header_parser_unit_checker checker_i (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .data_byte_i, .last_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .kind_i(kind_o), .frame_type_i(frame_type_o), .dst_mac_addr_i(dst_mac_addr_o),
    .source_mac_i(source_mac_o), .source_ip_i(source_ip_o), .dest_ip_i(dest_ip_o),
    .time_to_live_i(time_to_live_o), .ip_protocol_i(ip_protocol_o),
    .source_port_i(source_port_o), .dst_port_i(dst_port_o),
    .tcp_flag_bits_i(tcp_flag_bits_o), .transport_length_i(transport_length_o),
    .pending_o(pending), .fail_count_o(fail_count)
  );

  // Lay out one frame in frame_q: pad every byte, then drop the EtherType,
  // IHL nibble and protocol in where the frame is long enough to hold them.
  task automatic build_frame(input logic [15:0] etype, input logic [3:0] ihl,
                             input logic [7:0] proto, input int length, input pad_e pad);
    logic [7:0] b;
    frame_q.delete();
    for (int i = 0; i < length; i++) begin
      case (pad)
        PAD_ZERO: b = 8'h00;
        PAD_ONES: b = 8'hFF;
        default:  b = 8'($urandom);
      endcase
      frame_q.push_back(b);
    end
    if (length > 12) frame_q[12] = etype[15:8];
    if (length > 13) frame_q[13] = etype[7:0];
    if (length > 14) frame_q[14] = {frame_q[14][7:4], ihl};
    if (length > 23) frame_q[23] = proto;
  endtask

  // Offer one byte. Idle first at random (unless calm), then hold the item
  // steady until the parser takes it. Enter and leave at a falling edge.
  task automatic send_byte(input logic [7:0] b, input logic lst);
    while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid_i  <= 1'b0;
      data_byte_i <= 8'($urandom);
      last_i      <= 1'($urandom);
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_i      <= lst;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++) begin
      send_byte(frame_q[i], i == frame_q.size() - 1);
    end
    bytes_sent += frame_q.size();
  endtask

  // Receiver: random stalls, one long hold-off on request so that the output
  // register fills and the parser has to stall its input, none while calm.
  initial begin : receiver
    int held;
    held = 0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && held < HOLD_CYCLES) begin
        out_stall_i <= 1'b1;
        held++;
      end else if (calm) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < IDLE_PERCENT);
      end
    end
  end

  // Stimulus.
  initial begin : stimulus
    int frames;
    int ihl;
    int full;
    int len;
    logic [15:0] etype;
    logic [7:0]  proto;

    in_valid_i  = 1'b0;
    data_byte_i = 8'h00;
    last_i      = 1'b0;
    bytes_sent  = 0;
    rst_ni      = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed frames: runts, every EtherType class, bad and extreme IHL,
    // every protocol class, all-zero and all-one content, and captures that
    // stop inside the IP or transport header. A run of them goes by with no
    // idling on either side.
    build_frame(TYPE_IPV4, 4'd5, PROTO_TCP, 1, PAD_RANDOM);          send_frame();
    build_frame(TYPE_IPV4, 4'd5, PROTO_TCP, 13, PAD_ONES);           send_frame();
    build_frame(TYPE_IPV4, 4'd5, PROTO_TCP, 14, PAD_ONES);           send_frame();
    calm <= 1'b1;
    build_frame(TYPE_ARP, 4'd5, PROTO_TCP, 42, PAD_RANDOM);          send_frame();
    build_frame(TYPE_IPV6, 4'd5, PROTO_UDP, 54, PAD_RANDOM);         send_frame();
    build_frame(16'hFFFF, 4'hF, 8'hFF, 60, PAD_ONES);                send_frame();
    build_frame(16'h0000, 4'h0, 8'h00, 60, PAD_ZERO);                send_frame();
    build_frame(TYPE_IPV4, 4'd4, PROTO_TCP, 60, PAD_RANDOM);         send_frame();
    build_frame(TYPE_IPV4, 4'd0, PROTO_UDP, 60, PAD_ZERO);           send_frame();
    build_frame(TYPE_IPV4, 4'd5, PROTO_TCP, 48, PAD_ONES);           send_frame();
    calm <= 1'b0;
    build_frame(TYPE_IPV4, 4'hF, PROTO_TCP, 88, PAD_RANDOM);         send_frame();
    build_frame(TYPE_IPV4, 4'd5, PROTO_UDP, 42, PAD_RANDOM);         send_frame();
    build_frame(TYPE_IPV4, 4'hF, PROTO_UDP, 88, PAD_ONES);           send_frame();
    build_frame(TYPE_IPV4, 4'd5, PROTO_UDP, 64, PAD_ZERO);           send_frame();
    build_frame(TYPE_IPV4, 4'd5, PROTO_ICMP, 60, PAD_RANDOM);        send_frame();
    build_frame(TYPE_IPV4, 4'd5, 8'hFF, 40, PAD_RANDOM);             send_frame();
    build_frame(TYPE_IPV4, 4'd5, PROTO_TCP, 40, PAD_RANDOM);         send_frame();
    build_frame(TYPE_IPV4, 4'd5, PROTO_TCP, 30, PAD_RANDOM);         send_frame();

    // Random frames: mostly well-formed IPv4 with random content, some other
    // EtherTypes, bad IHL values and truncated captures mixed in. From the
    // second one on, the receiver takes its long hold-off.
    frames = 0;
    while (bytes_sent < TOTAL_BYTES) begin
      hold_req <= (frames >= 1);
      case ($urandom_range(9))
        0:       etype = TYPE_ARP;
        1:       etype = TYPE_IPV6;
        2:       etype = 16'($urandom);
        default: etype = TYPE_IPV4;
      endcase
      ihl = ($urandom_range(9) == 0) ? $urandom_range(4) : $urandom_range(15, 5);
      case ($urandom_range(9))
        0, 1, 2, 3: proto = PROTO_TCP;
        4, 5, 6:    proto = PROTO_UDP;
        7:          proto = PROTO_ICMP;
        default:    proto = 8'($urandom);
      endcase
      full = 14 + 4 * ((ihl < 5) ? 5 : ihl) + 14 + $urandom_range(12);
      len = ($urandom_range(4) == 0) ? $urandom_range(full, 1) : full;
      build_frame(etype, 4'(ihl), proto, len, PAD_RANDOM);
      send_frame();
      frames++;
    end
    in_valid_i <= 1'b0;

    // Drain: wait for every frame summary, then allow the output stage to
    // settle so that any stray item is still caught.
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin : watchdog
    #20000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
